// ===== hdl/odf_pkg.sv =====
`timescale 1ns / 1ps

package odf_pkg;

	localparam int ODF_DISP_WIDTH  = 200;
	localparam int ODF_DISP_HEIGHT = 200;

	// widest possible store: 32 bytes a row, 256 rows
	localparam int FB_ADDR_W  = 13;
	localparam int CFG_DATA_W = 64;

	typedef enum logic [1:0] {
		ACT_FILL = 2'd0,
		ACT_TAKE = 2'd1,
		ACT_READ = 2'd2,
		ACT_NONE = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		CFG_ROTATION = 2'd0,
		CFG_THR_LOW  = 2'd1,
		CFG_THR_HIGH = 2'd2
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_FILL,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic                 en;
		logic [FB_ADDR_W-1:0] addr;
		logic [7:0]           data;
	} ram_wr_t;

	typedef struct packed {
		logic       start;
		logic [7:0] xs;
		logic [7:0] xe;
		logic [7:0] ys;
		logic [7:0] ye;
		logic [7:0] gray;
	} walk_cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
	} walk_stat_t;

	typedef struct packed {
		logic       status;
		logic       dirty_empty;
		logic [7:0] dirty_top;
		logic [7:0] dirty_left;
		logic [7:0] dirty_right;
		logic [7:0] dirty_bottom;
		logic [7:0] read_data;
	} result_t;

endpackage

// ===== hdl/odf_item_if.sv =====
`timescale 1ns / 1ps

interface odf_item_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [7:0]  rect_x;
	logic [7:0]  rect_y;
	logic [8:0]  rect_w;
	logic [8:0]  rect_h;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;
	logic [12:0] byte_address;

	modport source (
		output valid, action, rect_x, rect_y, rect_w, rect_h, red, green, blue,
			byte_address,
		input  ready
	);

	modport sink (
		input  valid, action, rect_x, rect_y, rect_w, rect_h, red, green, blue,
			byte_address,
		output ready
	);
endinterface

// ===== hdl/odf_result_if.sv =====
`timescale 1ns / 1ps

interface odf_result_if;
	logic       valid;
	logic       ready;
	logic       status;
	logic       dirty_empty;
	logic [7:0] dirty_top;
	logic [7:0] dirty_left;
	logic [7:0] dirty_right;
	logic [7:0] dirty_bottom;
	logic [7:0] read_data;

	modport source (
		output valid, status, dirty_empty, dirty_top, dirty_left, dirty_right,
			dirty_bottom, read_data,
		input  ready
	);

	modport sink (
		input  valid, status, dirty_empty, dirty_top, dirty_left, dirty_right,
			dirty_bottom, read_data,
		output ready
	);
endinterface

// ===== hdl/ordered_dither_framebuffer_fill_top.sv =====
`timescale 1ns / 1ps
// take, rejected and unknown actions: the result goes through ST_DONE into the output register once it is free
// read: the result goes through ST_READ and the registered memory read, then ST_DONE
// fill: every byte spanned in every row is read, merged and written back; the memory's read and
// write ports do one read-modify-write of a byte per cycle, one item in flight at a time
// reset: the frame store is swept to zero, all ROW_BYTES * DISP_HEIGHT bytes
// (5000 by default), with no item accepted; registers with a reset clear at once

module ordered_dither_framebuffer_fill_top
	import odf_pkg::*;
#(
	parameter int DISP_WIDTH  = ODF_DISP_WIDTH,
	parameter int DISP_HEIGHT = ODF_DISP_HEIGHT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [1:0]            cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	odf_item_if.sink              item,
	odf_result_if.source          result
);

	localparam int ROW_BYTES   = (DISP_WIDTH + 7) / 8;
	localparam int STORE_BYTES = ROW_BYTES * DISP_HEIGHT;
	localparam logic [FB_ADDR_W-1:0] CLR_LAST = FB_ADDR_W'(STORE_BYTES - 1);

	state_t state_q, state_d;

	logic [2:0]            rot_q;
	logic [CFG_DATA_W-1:0] thr_low_q, thr_high_q;
	logic [8:0]            bound_top_q, bound_left_q;
	logic [7:0]            bound_right_q, bound_bottom_q;
	logic [FB_ADDR_W-1:0]  clr_q;
	result_t               pend_q, out_q, pend_new;
	logic                  out_valid_q;

	action_t    act;
	logic       accept, load_out, rd_idle, rd_in_range;
	logic       fill_reject, mirror_x, mirror_y, bounds_empty;
	logic [8:0] lw, lh;
	logic [9:0] x_sum, y_sum, gray_sum;
	logic [7:0] xe0, ye0, xs1, xe1, ys1, ye1, xs2, xe2, ys2, ye2;

	walk_cmd_t            wk_cmd;
	walk_stat_t           wk_stat;
	logic                 wk_rd_en, ram_rd_en;
	logic [FB_ADDR_W-1:0] wk_rd_addr, ram_rd_addr;
	ram_wr_t              wk_wr, ram_wr;
	logic [7:0]           ram_rd_data;

	assign act    = action_t'(item.action);
	assign accept = item.valid && item.ready;
	assign item.ready = (state_q == ST_IDLE);

	assign rd_in_range = int'(item.byte_address) < STORE_BYTES;

	// rectangle check and mapping onto the panel
	always_comb begin
		lw = rot_q[0] ? 9'(DISP_HEIGHT) : 9'(DISP_WIDTH);
		lh = rot_q[0] ? 9'(DISP_WIDTH) : 9'(DISP_HEIGHT);
		x_sum = {2'b00, item.rect_x} + {1'b0, item.rect_w};
		y_sum = {2'b00, item.rect_y} + {1'b0, item.rect_h};
		fill_reject = (item.rect_w == 9'd0) || (item.rect_h == 9'd0) ||
			(x_sum > {1'b0, lw}) || (y_sum > {1'b0, lh});
		xe0 = 8'(x_sum - 10'd1);
		ye0 = 8'(y_sum - 10'd1);
		if (rot_q[0]) begin
			xs1 = item.rect_y;
			xe1 = ye0;
			ys1 = item.rect_x;
			ye1 = xe0;
		end else begin
			xs1 = item.rect_x;
			xe1 = xe0;
			ys1 = item.rect_y;
			ye1 = ye0;
		end
		case (rot_q) inside
			3'd1, 3'd2, 3'd6, 3'd7: mirror_x = 1'b1;
			default:                mirror_x = 1'b0;
		endcase
		case (rot_q) inside
			3'd2, 3'd3, 3'd4, 3'd7: mirror_y = 1'b1;
			default:                mirror_y = 1'b0;
		endcase
		xs2 = mirror_x ? 8'(DISP_WIDTH - 1 - int'(xe1)) : xs1;
		xe2 = mirror_x ? 8'(DISP_WIDTH - 1 - int'(xs1)) : xe1;
		ys2 = mirror_y ? 8'(DISP_HEIGHT - 1 - int'(ye1)) : ys1;
		ye2 = mirror_y ? 8'(DISP_HEIGHT - 1 - int'(ys1)) : ye1;
		gray_sum = {2'b00, item.red} + {1'b0, item.green, 1'b0} + {2'b00, item.blue};
	end

	assign bounds_empty = (bound_left_q > {1'b0, bound_right_q}) ||
		(bound_top_q > {1'b0, bound_bottom_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		load_out = 1'b0;
		rd_idle  = 1'b0;
		wk_cmd.start = 1'b0;
		wk_cmd.xs    = xs2;
		wk_cmd.xe    = xe2;
		wk_cmd.ys    = ys2;
		wk_cmd.ye    = ye2;
		wk_cmd.gray  = gray_sum[9:2];
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_q == CLR_LAST) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (item.valid) begin
					unique case (act)
						ACT_FILL: begin
							wk_cmd.start = !fill_reject;
							state_d = fill_reject ? ST_DONE : ST_FILL;
						end
						ACT_READ: begin
							rd_idle = rd_in_range;
							state_d = rd_in_range ? ST_READ : ST_DONE;
						end
						default: state_d = ST_DONE;
					endcase
				end
			end
			ST_READ: state_d = ST_DONE;
			ST_FILL: begin
				if (wk_stat.done) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || result.ready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_q      <= '0;
			thr_low_q  <= '0;
			thr_high_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_ROTATION: rot_q      <= cfg_data[2:0];
				CFG_THR_LOW:  thr_low_q  <= cfg_data;
				CFG_THR_HIGH: thr_high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bound_top_q    <= 9'(DISP_HEIGHT);
			bound_left_q   <= 9'(DISP_WIDTH);
			bound_right_q  <= '0;
			bound_bottom_q <= '0;
			clr_q          <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
			if (accept && act == ACT_FILL && !fill_reject) begin
				if ({1'b0, ys2} < bound_top_q)  bound_top_q    <= {1'b0, ys2};
				if ({1'b0, xs2} < bound_left_q) bound_left_q   <= {1'b0, xs2};
				if (xe2 > bound_right_q)        bound_right_q  <= xe2;
				if (ye2 > bound_bottom_q)       bound_bottom_q <= ye2;
			end else if (accept && act == ACT_TAKE) begin
				bound_top_q    <= 9'(DISP_HEIGHT);
				bound_left_q   <= 9'(DISP_WIDTH);
				bound_right_q  <= '0;
				bound_bottom_q <= '0;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		pend_new = '0;
		case (act)
			ACT_FILL: pend_new.status = fill_reject;
			ACT_TAKE: begin
				pend_new.dirty_empty = bounds_empty;
				if (!bounds_empty) begin
					pend_new.dirty_top    = bound_top_q[7:0];
					pend_new.dirty_left   = bound_left_q[7:0];
					pend_new.dirty_right  = bound_right_q;
					pend_new.dirty_bottom = bound_bottom_q;
				end
			end
			ACT_READ: pend_new.status = !rd_in_range;
			default:  pend_new.status = 1'b1;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pend_q <= pend_new;
		end else if (state_q == ST_READ) begin
			pend_q.read_data <= ram_rd_data;
		end
		if (load_out) out_q <= pend_q;
	end

	assign result.valid        = out_valid_q;
	assign result.status       = out_q.status;
	assign result.dirty_empty  = out_q.dirty_empty;
	assign result.dirty_top    = out_q.dirty_top;
	assign result.dirty_left   = out_q.dirty_left;
	assign result.dirty_right  = out_q.dirty_right;
	assign result.dirty_bottom = out_q.dirty_bottom;
	assign result.read_data    = out_q.read_data;

	// memory port sharing: clearing sweep, byte read, fill walker
	always_comb begin
		if (state_q == ST_CLEAR) begin
			ram_wr.en   = 1'b1;
			ram_wr.addr = clr_q;
			ram_wr.data = 8'd0;
		end else begin
			ram_wr = wk_wr;
		end
		ram_rd_en   = rd_idle || wk_rd_en;
		ram_rd_addr = (state_q == ST_FILL) ? wk_rd_addr : item.byte_address;
	end

	odf_byte_walker #(
		.DISP_WIDTH(DISP_WIDTH)
	) u_walker (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (wk_cmd),
		.thr_low  (thr_low_q),
		.thr_high (thr_high_q),
		.rd_data  (ram_rd_data),
		.rd_en    (wk_rd_en),
		.rd_addr  (wk_rd_addr),
		.wr       (wk_wr),
		.stat     (wk_stat)
	);

	odf_frame_ram #(
		.DEPTH(STORE_BYTES)
	) u_ram (
		.clk     (clk),
		.wr      (ram_wr),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	a_walker_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE || state_q == ST_CLEAR) |-> !wk_stat.busy)
		else $error("fill walker busy outside a fill");

	a_done_in_fill: assert property (@(posedge clk) disable iff (!arst_n)
		wk_stat.done |-> state_q == ST_FILL)
		else $error("fill completion outside a fill");

	a_ram_wr_state: assert property (@(posedge clk) disable iff (!arst_n)
		ram_wr.en |-> (state_q == ST_CLEAR || state_q == ST_FILL))
		else $error("frame store written outside clear or fill");

	a_reject_keeps_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && act == ACT_FILL && fill_reject) |=>
		($stable(bound_top_q) && $stable(bound_left_q) &&
		$stable(bound_right_q) && $stable(bound_bottom_q)))
		else $error("rejected fill changed the dirty bounds");

endmodule

// ===== hdl/odf_frame_ram.sv =====
`timescale 1ns / 1ps

module odf_frame_ram
	import odf_pkg::*;
#(
	parameter int DEPTH = 5000
) (
	input  logic                 clk,
	input  ram_wr_t              wr,
	input  logic                 rd_en,
	input  logic [FB_ADDR_W-1:0] rd_addr,
	output logic [7:0]           rd_data
);

	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr[ADDR_W-1:0]] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr[ADDR_W-1:0]];
		end
	end

endmodule

// ===== hdl/odf_byte_walker.sv =====
`timescale 1ns / 1ps

module odf_byte_walker
	import odf_pkg::*;
#(
	parameter int DISP_WIDTH = ODF_DISP_WIDTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  walk_cmd_t             cmd,
	input  logic [CFG_DATA_W-1:0] thr_low,
	input  logic [CFG_DATA_W-1:0] thr_high,
	input  logic [7:0]            rd_data,
	output logic                  rd_en,
	output logic [FB_ADDR_W-1:0]  rd_addr,
	output ram_wr_t               wr,
	output walk_stat_t            stat
);

	localparam int ROW_BYTES = (DISP_WIDTH + 7) / 8;

	logic                   active_q;
	logic [7:0]             xs_q, xe_q, py_q, ye_q, gray_q;
	logic [4:0]             bx_q;
	logic [FB_ADDR_W-1:0]   row_base_q;

	logic                   valid_s1, last_s1;
	logic [FB_ADDR_W-1:0]   addr_s1;
	logic [7:0]             mask_s1, bits_s1;

	logic [2*CFG_DATA_W-1:0] thr_all;
	logic [3:0]             pat;
	logic [7:0]             mask, bits;
	logic [2:0]             lo, hi;
	logic                   row_end, last;

	assign thr_all = {thr_high, thr_low};

	// one compare per threshold column of the current row
	always_comb begin
		for (int j = 0; j < 4; j++) begin
			pat[j] = ({1'b0, gray_q} + {1'b0, thr_all[{py_q[1:0], 2'(j)} * 8 +: 8]})
				>= 9'd256;
		end
		for (int j = 0; j < 8; j++) begin
			bits[7 - j] = pat[j % 4];
		end
	end

	// pixels of this byte that lie inside the rectangle
	always_comb begin
		lo = (bx_q == xs_q[7:3]) ? xs_q[2:0] : 3'd0;
		hi = (bx_q == xe_q[7:3]) ? xe_q[2:0] : 3'd7;
		for (int j = 0; j < 8; j++) begin
			mask[7 - j] = (3'(j) >= lo) && (3'(j) <= hi);
		end
	end

	assign row_end = (bx_q == xe_q[7:3]);
	assign last    = row_end && (py_q == ye_q);
	assign rd_en   = active_q;
	assign rd_addr = FB_ADDR_W'(row_base_q + {{(FB_ADDR_W - 5){1'b0}}, bx_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= active_q;
			if (cmd.start) begin
				active_q <= 1'b1;
			end else if (active_q && last) begin
				active_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			xs_q       <= cmd.xs;
			xe_q       <= cmd.xe;
			ye_q       <= cmd.ye;
			py_q       <= cmd.ys;
			gray_q     <= cmd.gray;
			bx_q       <= cmd.xs[7:3];
			row_base_q <= FB_ADDR_W'(int'(cmd.ys) * ROW_BYTES);
		end else if (active_q) begin
			if (row_end) begin
				bx_q       <= xs_q[7:3];
				py_q       <= py_q + 8'd1;
				row_base_q <= FB_ADDR_W'(int'(row_base_q) + ROW_BYTES);
			end else begin
				bx_q <= bx_q + 5'd1;
			end
		end
		last_s1 <= last;
		addr_s1 <= rd_addr;
		mask_s1 <= mask;
		bits_s1 <= bits;
	end

	// merge the new pixels into the byte returned by the registered read
	assign wr.en   = valid_s1;
	assign wr.addr = addr_s1;
	assign wr.data = (rd_data & ~mask_s1) | (bits_s1 & mask_s1);

	assign stat.busy = active_q || valid_s1;
	assign stat.done = valid_s1 && last_s1;

	a_wr_follows_rd: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (addr_s1 == $past(rd_addr)) && $past(rd_en))
		else $error("write back does not match the byte read");

endmodule
